/* hdl/rmth_pkg.sv */
`default_nettype none
package rmth_pkg;

    localparam int CAPACITY     = 1024;
    localparam int SAMPLE_WIDTH = 16;

    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_POP    = 2'd2
    } t_op;

endpackage
`default_nettype wire

/* hdl/running_median_two_heaps.sv */
// Channel   Valid         Stall         Payload
// input     i_in_valid    o_in_stall    i_sample
// output    o_out_valid   i_out_stall   o_median_times_two, o_sample_count, o_overflow
//
// After its transfer a sample goes through S_DECIDE, then S_SECOND when a heap top
// moves to the other half, and S_DONE before the input is free again: each cell row
// does one insert or pop per cycle. A dropped sample (store full) skips S_SECOND.
// Reset empties both rows; cell contents are not cleared.
// A stalled output holds the result; the next sample still runs and waits at the end.
`default_nettype none
module running_median_two_heaps #(
    parameter int CAPACITY     = rmth_pkg::CAPACITY,
    parameter int SAMPLE_WIDTH = rmth_pkg::SAMPLE_WIDTH,
    localparam int HALF        = (CAPACITY + 1) / 2,
    localparam int SIZE_W      = $clog2(HALF + 1),
    localparam int CNT_W       = $clog2(CAPACITY + 1),
    localparam int MED_W       = SAMPLE_WIDTH + 1
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_sample,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic signed [MED_W-1:0]             o_median_times_two,
    output logic [CNT_W-1:0]                    o_sample_count,
    output logic                                o_overflow
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_DECIDE = 4'b0010,
        S_SECOND = 4'b0100,
        S_DONE   = 4'b1000
    } t_state;

    t_state                         r_state;
    t_state                         n_state;
    logic signed [SAMPLE_WIDTH-1:0] r_sample;
    logic                           r_drop;
    logic                           n_drop;
    logic                           r_second_upper;
    logic                           n_second_upper;

    logic                           r_out_valid;
    logic signed [MED_W-1:0]        r_median;
    logic [CNT_W-1:0]               r_count;
    logic                           r_overflow;

    rmth_pkg::t_op                  w_lower_op;
    rmth_pkg::t_op                  w_upper_op;
    logic signed [SAMPLE_WIDTH-1:0] w_lower_key;
    logic signed [SAMPLE_WIDTH-1:0] w_upper_key;
    logic signed [SAMPLE_WIDTH-1:0] w_lower_top;
    logic signed [SAMPLE_WIDTH-1:0] w_upper_top;
    logic signed [SAMPLE_WIDTH-1:0] w_up_value;
    logic [SIZE_W-1:0]              w_lower_size;
    logic [SIZE_W-1:0]              w_upper_size;
    logic [CNT_W-1:0]               w_count;
    logic                           w_full;
    logic                           w_to_lower;
    logic                           w_equal;
    logic                           w_in_accept;
    logic                           w_out_load;
    logic signed [MED_W-1:0]        w_lo_ext;
    logic signed [MED_W-1:0]        w_up_ext;
    logic signed [MED_W-1:0]        w_median;

    rmth_chain #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .DEPTH        (HALF)
    ) u_lower (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (w_lower_op),
        .i_key   (w_lower_key),
        .o_top   (w_lower_top),
        .o_size  (w_lower_size)
    );

    // upper half is stored inverted so that both rows keep their maximum at the head
    rmth_chain #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .DEPTH        (HALF)
    ) u_upper (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (w_upper_op),
        .i_key   (w_upper_key),
        .o_top   (w_upper_top),
        .o_size  (w_upper_size)
    );

    assign w_up_value  = ~w_upper_top;
    assign w_count     = CNT_W'(w_lower_size) + CNT_W'(w_upper_size);
    assign w_full      = (w_count >= CNT_W'(CAPACITY));
    assign w_equal     = (w_lower_size == w_upper_size);
    assign w_to_lower  = (w_lower_size == '0) || (w_lower_top >= r_sample);
    assign o_in_stall  = (r_state != S_IDLE);
    assign w_in_accept = i_in_valid && !o_in_stall;
    assign w_out_load  = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    assign w_lo_ext = {w_lower_top[SAMPLE_WIDTH-1], w_lower_top};
    assign w_up_ext = {w_up_value[SAMPLE_WIDTH-1], w_up_value};

    always_comb begin
        if (w_lower_size == '0) begin
            w_median = '0;
        end else if (w_equal) begin
            w_median = w_lo_ext + w_up_ext;
        end else begin
            w_median = {w_lower_top, 1'b0};
        end
    end

    always_comb begin
        n_state        = r_state;
        n_drop         = r_drop;
        n_second_upper = r_second_upper;
        w_lower_op     = rmth_pkg::OP_HOLD;
        w_upper_op     = rmth_pkg::OP_HOLD;
        w_lower_key    = r_sample;
        w_upper_key    = ~r_sample;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_accept) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_drop  = w_full;
                n_state = S_DONE;
                if (!w_full) begin
                    if (w_to_lower) begin
                        if (!w_equal) begin
                            w_lower_op     = rmth_pkg::OP_POP;
                            w_upper_op     = rmth_pkg::OP_INSERT;
                            w_upper_key    = ~w_lower_top;
                            n_second_upper = 1'b0;
                            n_state        = S_SECOND;
                        end else begin
                            w_lower_op = rmth_pkg::OP_INSERT;
                        end
                    end else if (w_equal) begin
                        if ((w_upper_size == '0) || (r_sample <= w_up_value)) begin
                            w_lower_op = rmth_pkg::OP_INSERT;
                        end else begin
                            w_upper_op     = rmth_pkg::OP_POP;
                            w_lower_op     = rmth_pkg::OP_INSERT;
                            w_lower_key    = w_up_value;
                            n_second_upper = 1'b1;
                            n_state        = S_SECOND;
                        end
                    end else begin
                        w_upper_op = rmth_pkg::OP_INSERT;
                    end
                end
            end
            S_SECOND: begin
                if (r_second_upper) begin
                    w_upper_op = rmth_pkg::OP_INSERT;
                end else begin
                    w_lower_op = rmth_pkg::OP_INSERT;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_drop         <= n_drop;
        r_second_upper <= n_second_upper;
        if (w_in_accept) begin
            r_sample <= i_sample;
        end
        if (w_out_load) begin
            r_median   <= w_median;
            r_count    <= w_count;
            r_overflow <= r_drop;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_median_times_two = r_median;
    assign o_sample_count     = r_count;
    assign o_overflow         = r_overflow;

    a_balance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_SECOND) |->
        ((w_lower_size == w_upper_size) || (w_lower_size == w_upper_size + 1'b1)))
        else $error("heap halves out of balance");

    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && w_upper_size != '0) |-> (w_lower_top <= w_up_value))
        else $error("lower top above upper top");

    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_overflow) |-> (r_count == CNT_W'(CAPACITY)))
        else $error("overflow flagged below capacity");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_accept |=> o_in_stall)
        else $error("input taken while a sample is in work");

endmodule
`default_nettype wire

/* hdl/rmth_cell.sv */
`default_nettype none
module rmth_cell #(
    parameter int SAMPLE_WIDTH = rmth_pkg::SAMPLE_WIDTH
) (
    input  wire logic                           i_clk,
    input  wire rmth_pkg::t_op                  i_op,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_key,
    input  wire logic                           i_occupied,
    input  wire logic                           i_left_keep,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_left_value,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_right_value,
    output logic                                o_keep,
    output logic signed [SAMPLE_WIDTH-1:0]      o_value
);

    logic signed [SAMPLE_WIDTH-1:0] r_value;
    logic signed [SAMPLE_WIDTH-1:0] n_value;

    assign o_keep  = i_occupied && (r_value >= i_key);
    assign o_value = r_value;

    always_comb begin
        n_value = r_value;
        unique case (i_op)
            rmth_pkg::OP_INSERT: begin
                if (!o_keep) begin
                    n_value = i_left_keep ? i_key : i_left_value;
                end
            end
            rmth_pkg::OP_POP: begin
                n_value = i_right_value;
            end
            default: begin
                n_value = r_value;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule
`default_nettype wire

/* hdl/rmth_chain.sv */
`default_nettype none
module rmth_chain #(
    parameter int SAMPLE_WIDTH = rmth_pkg::SAMPLE_WIDTH,
    parameter int DEPTH        = (rmth_pkg::CAPACITY + 1) / 2,
    localparam int SIZE_W      = $clog2(DEPTH + 1)
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire rmth_pkg::t_op                  i_op,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_key,
    output logic signed [SAMPLE_WIDTH-1:0]      o_top,
    output logic [SIZE_W-1:0]                   o_size
);

    logic signed [SAMPLE_WIDTH-1:0] w_value       [DEPTH];
    logic signed [SAMPLE_WIDTH-1:0] w_left_value  [DEPTH];
    logic signed [SAMPLE_WIDTH-1:0] w_right_value [DEPTH];
    logic [DEPTH-1:0]               w_keep;
    logic [DEPTH-1:0]               w_left_keep;
    logic [DEPTH-1:0]               w_occupied;
    logic [SIZE_W-1:0]              r_size;
    logic [SIZE_W-1:0]              n_size;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        if (g == 0) begin : g_head
            assign w_left_keep[g]  = 1'b1;
            assign w_left_value[g] = i_key;
        end else begin : g_body
            assign w_left_keep[g]  = w_keep[g-1];
            assign w_left_value[g] = w_value[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign w_right_value[g] = '0;
        end else begin : g_link
            assign w_right_value[g] = w_value[g+1];
        end

        assign w_occupied[g] = (r_size > SIZE_W'(g));

        rmth_cell #(
            .SAMPLE_WIDTH (SAMPLE_WIDTH)
        ) u_cell (
            .i_clk         (i_clk),
            .i_op          (i_op),
            .i_key         (i_key),
            .i_occupied    (w_occupied[g]),
            .i_left_keep   (w_left_keep[g]),
            .i_left_value  (w_left_value[g]),
            .i_right_value (w_right_value[g]),
            .o_keep        (w_keep[g]),
            .o_value       (w_value[g])
        );
    end

    always_comb begin
        n_size = r_size;
        unique case (i_op)
            rmth_pkg::OP_INSERT: n_size = r_size + 1'b1;
            rmth_pkg::OP_POP:    n_size = r_size - 1'b1;
            default:             n_size = r_size;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= '0;
        end else begin
            r_size <= n_size;
        end
    end

    assign o_top  = w_value[0];
    assign o_size = r_size;

endmodule
`default_nettype wire
